### src/mesh_node_degree_counter_assert.svh
// assertion macros for the mesh node degree counter
// used by the top level only
`ifndef MESH_NODE_DEGREE_COUNTER_ASSERT_SVH
`define MESH_NODE_DEGREE_COUNTER_ASSERT_SVH
`define MNDC_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define MNDC_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

### src/mndc_pkg.sv
// types, constants and edge tables for the mesh node degree counter
// no dependencies
package mndc_pkg;
    localparam logic [3:0] NONE_LOCAL = 4'd15;
    localparam logic [2:0] TYPE_TETRA = 3'd0;
    localparam logic [2:0] TYPE_PYRAMID = 3'd4;

    function automatic logic [3:0] corner_count(input logic [2:0] t);
        logic [3:0] r;
        case (t)
            3'd0: r = 4'd4;
            3'd1: r = 4'd8;
            3'd2: r = 4'd8;
            3'd3: r = 4'd6;
            3'd4: r = 4'd5;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // local neighbour id of corner c, slot j
    function automatic logic [3:0] edge_loc(input logic [2:0] t, input logic [2:0] c,
                                            input logic [1:0] j);
        logic [15:0] row;
        case ({t, c})
            6'o00: row = 16'hF321; 6'o01: row = 16'hF320;
            6'o02: row = 16'hF310; 6'o03: row = 16'hF210;
            6'o10: row = 16'hF431; 6'o11: row = 16'hF520;
            6'o12: row = 16'hF631; 6'o13: row = 16'hF720;
            6'o14: row = 16'hF750; 6'o15: row = 16'hF641;
            6'o16: row = 16'hF752; 6'o17: row = 16'hF643;
            6'o20: row = 16'hF421; 6'o21: row = 16'hF530;
            6'o22: row = 16'hF630; 6'o23: row = 16'hF721;
            6'o24: row = 16'hF650; 6'o25: row = 16'hF741;
            6'o26: row = 16'hF742; 6'o27: row = 16'hF653;
            6'o30: row = 16'hF321; 6'o31: row = 16'hF420;
            6'o32: row = 16'hF510; 6'o33: row = 16'hF540;
            6'o34: row = 16'hF531; 6'o35: row = 16'hF432;
            6'o40: row = 16'hF431; 6'o41: row = 16'hF420;
            6'o42: row = 16'hF431; 6'o43: row = 16'hF420;
            6'o44: row = 16'h3210;
            default: row = 16'hFFFF;
        endcase
        return row[{j, 2'b00} +: 4];
    endfunction

    typedef struct packed {
        logic       start;
        logic [2:0] cell_type;
    } mndc_ctl_t;

    typedef struct packed {
        logic busy;
        logic ovf;
    } mndc_sts_t;
endpackage

### src/mndc_list_unit.sv
// per-node neighbour list: count memory and store memory with read-modify-write
// depends on mndc_pkg
module mndc_list_unit import mndc_pkg::*; #(
    parameter int NODE_COUNT = 4096,
    parameter int MAX_DEGREE = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    input  logic [$clog2(NODE_COUNT)-1:0] op_node,
    input  logic [11:0]                   op_nb,
    output logic                          op_done,
    output logic                          op_drop,
    input  logic                          q_valid,
    input  logic [$clog2(NODE_COUNT)-1:0] q_node,
    output logic [6:0]                    q_count,
    output logic                          clear_busy
);
    localparam int NW = $clog2(NODE_COUNT);
    localparam int DW = $clog2(MAX_DEGREE);
    localparam int CW = DW + 1;

    localparam logic [2:0] S_CLR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CNT = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_CMP = 3'd4;

    logic [CW-1:0] cnt_mem [NODE_COUNT];
    logic [11:0]   nb_mem [NODE_COUNT*(2**DW)];

    logic [2:0]    state_reg, state_next;
    logic [NW-1:0] clr_reg, clr_next;
    logic [CW-1:0] cnt_rd, cnt_reg, cnt_next;
    logic [CW-1:0] k_reg, k_next;
    logic [11:0]   nb_rd;
    logic          cnt_we, nb_we;
    logic [NW-1:0] cnt_wa, cnt_ra;
    logic [CW-1:0] cnt_wd;
    logic [NW+DW-1:0] nb_wa, nb_ra;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_wa] <= cnt_wd;
        cnt_rd <= cnt_mem[cnt_ra];
        if (nb_we)
            nb_mem[nb_wa] <= op_nb;
        nb_rd <= nb_mem[nb_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            cnt_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            cnt_reg <= cnt_next;
            k_reg <= k_next;
        end
    end

    assign cnt_ra = q_valid ? q_node : op_node;
    assign nb_ra = {op_node, k_next[DW-1:0]};
    assign nb_wa = {op_node, cnt_reg[DW-1:0]};
    assign q_count = 7'(cnt_rd);
    assign clear_busy = (state_reg == S_CLR);

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        cnt_we = 1'b0;
        cnt_wa = op_node;
        cnt_wd = cnt_reg + CW'(1);
        nb_we = 1'b0;
        op_done = 1'b0;
        op_drop = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                cnt_we = 1'b1;
                cnt_wa = clr_reg;
                cnt_wd = '0;
                clr_next = clr_reg + NW'(1);
                if (clr_reg == NW'(NODE_COUNT - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (op_valid)
                    state_next = S_CNT;
            end
            S_CNT:
            begin
                cnt_next = cnt_rd;
                k_next = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // nb_rd for entry k arrives next cycle
                if (k_reg >= cnt_reg)
                begin
                    op_done = 1'b1;
                    state_next = S_IDLE;
                    if (cnt_reg >= CW'(MAX_DEGREE))
                        op_drop = 1'b1;
                    else
                    begin
                        nb_we = 1'b1;
                        cnt_we = 1'b1;
                    end
                end
                else
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                if (nb_rd == op_nb)
                begin
                    op_done = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                    state_next = S_SCAN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

### src/mndc_cell_seq.sv
// steps through corners and edge slots of one cell, issuing list requests
// depends on mndc_pkg
module mndc_cell_seq import mndc_pkg::*; #(
    parameter int NODE_COUNT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mndc_ctl_t                     ctl,
    input  logic [11:0]                   pts [8],
    output logic                          op_valid,
    output logic [$clog2(NODE_COUNT)-1:0] op_node,
    output logic [11:0]                   op_nb,
    input  logic                          op_done,
    input  logic                          op_drop,
    output mndc_sts_t                     sts
);
    localparam int NW = $clog2(NODE_COUNT);

    logic       busy_reg, busy_next;
    logic       ovf_reg, ovf_next;
    logic       wait_reg, wait_next;
    logic [2:0] c_reg, c_next;
    logic [1:0] j_reg, j_next;
    logic [3:0] loc;
    logic [11:0] node_id;
    logic        skip;
    logic        last_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ovf_reg <= 1'b0;
            wait_reg <= 1'b0;
            c_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ovf_reg <= ovf_next;
            wait_reg <= wait_next;
            c_reg <= c_next;
            j_reg <= j_next;
        end
    end

    assign loc = edge_loc(ctl.cell_type, c_reg, j_reg);
    assign node_id = pts[c_reg];
    assign skip = (loc == NONE_LOCAL) || (32'(node_id) >= NODE_COUNT);
    assign op_node = NW'(node_id);
    assign op_nb = pts[loc[2:0]];
    assign op_valid = busy_reg && !wait_reg && !skip;
    assign sts.busy = busy_reg;
    assign sts.ovf = ovf_reg;
    assign last_slot = (j_reg == 2'd3) && ({1'b0, c_reg} == corner_count(ctl.cell_type) - 4'd1);

    always_comb
    begin
        busy_next = busy_reg;
        ovf_next = ovf_reg;
        wait_next = wait_reg;
        c_next = c_reg;
        j_next = j_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            ovf_next = 1'b0;
            wait_next = 1'b0;
            c_next = '0;
            j_next = '0;
        end
        else if (busy_reg)
        begin
            if (!wait_reg && !skip)
                wait_next = 1'b1;
            else if (!wait_reg || op_done)
            begin
                wait_next = 1'b0;
                if (op_done && op_drop)
                    ovf_next = 1'b1;
                j_next = j_reg + 2'd1;
                if (j_reg == 2'd3)
                    c_next = c_reg + 3'd1;
                if (last_slot)
                    busy_next = 1'b0;
            end
        end
    end
endmodule

### src/mesh_node_degree_counter.sv
// mesh node degree counter top level, one request at a time; depends on mndc_pkg,
// mndc_cell_seq, mndc_list_unit and mesh_node_degree_counter_assert.svh
// a query passes through T_QRY; a bad cell type goes straight to the output registers;
// an add walks the slots, skipping absent ones and else comparing each list entry
// the next request can be taken in the cycle its result leaves, unless out_stall holds the result
// reset: asynchronous; a clearing pass zeroes the counts, no request meanwhile
`include "mesh_node_degree_counter_assert.svh"
module mesh_node_degree_counter import mndc_pkg::*; #(
    parameter int NODE_COUNT = 4096,
    parameter int MAX_DEGREE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [2:0]  cell_type,
    input  logic [11:0] point_0,
    input  logic [11:0] point_1,
    input  logic [11:0] point_2,
    input  logic [11:0] point_3,
    input  logic [11:0] point_4,
    input  logic [11:0] point_5,
    input  logic [11:0] point_6,
    input  logic [11:0] point_7,
    input  logic [11:0] node_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  degree,
    output logic        bad_cell_type,
    output logic        list_overflow
);
    localparam int NW = $clog2(NODE_COUNT);
    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_QRY = 2'd1;
    localparam logic [1:0] T_ADD = 2'd2;
    localparam logic [1:0] T_OUT = 2'd3;

    logic [1:0]  st_reg, st_next;
    logic [11:0] pts_reg [8];
    logic [2:0]  type_reg;
    logic        qok_reg;
    logic        ov_reg, ov_next;
    logic [5:0]  deg_reg, deg_next;
    logic        bad_reg, bad_next;
    logic        ovf_reg, ovf_next;
    logic        acc;
    logic        started_reg;
    logic        add_start;
    mndc_sts_t   sts;
    logic        op_valid, op_done, op_drop, clear_busy;
    logic [NW-1:0] op_node;
    logic [11:0] op_nb;
    logic [6:0]  q_count;

    assign in_stall = clear_busy || (st_reg != T_IDLE) || (ov_reg && out_stall);
    assign acc = in_valid && !in_stall;
    assign add_start = acc && !action && (cell_type <= TYPE_PYRAMID);

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pts_reg[0] <= point_0; pts_reg[1] <= point_1;
            pts_reg[2] <= point_2; pts_reg[3] <= point_3;
            pts_reg[4] <= point_4; pts_reg[5] <= point_5;
            pts_reg[6] <= point_6; pts_reg[7] <= point_7;
            type_reg <= cell_type;
            qok_reg <= 32'(node_index) < NODE_COUNT;
        end
    end

    // sequencer sees cell type at start through the registered copy, in the cycle after the request is taken
    logic start_d_reg;
    mndc_ctl_t ctl_d;
    assign ctl_d.start = start_d_reg;
    assign ctl_d.cell_type = type_reg;

    mndc_cell_seq #(.NODE_COUNT(NODE_COUNT)) u_seq (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_d), .pts(pts_reg),
        .op_valid(op_valid), .op_node(op_node), .op_nb(op_nb),
        .op_done(op_done), .op_drop(op_drop), .sts(sts)
    );

    mndc_list_unit #(.NODE_COUNT(NODE_COUNT), .MAX_DEGREE(MAX_DEGREE)) u_list (
        .clk(clk), .rst_n(rst_n), .op_valid(op_valid), .op_node(op_node),
        .op_nb(op_nb), .op_done(op_done), .op_drop(op_drop),
        .q_valid(acc && action), .q_node(NW'(node_index)),
        .q_count(q_count), .clear_busy(clear_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= T_IDLE;
            ov_reg <= 1'b0;
            start_d_reg <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            start_d_reg <= add_start;
            started_reg <= start_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        deg_reg <= deg_next;
        bad_reg <= bad_next;
        ovf_reg <= ovf_next;
    end

    always_comb
    begin
        st_next = st_reg;
        ov_next = ov_reg && out_stall;
        deg_next = deg_reg;
        bad_next = bad_reg;
        ovf_next = ovf_reg;
        case (st_reg)
            T_IDLE:
            begin
                if (acc)
                begin
                    if (action)
                        st_next = T_QRY;
                    else if (cell_type <= TYPE_PYRAMID)
                        st_next = T_ADD;
                    else
                    begin
                        ov_next = 1'b1;
                        deg_next = '0;
                        bad_next = 1'b1;
                        ovf_next = 1'b0;
                    end
                end
            end
            T_QRY:
            begin
                ov_next = 1'b1;
                deg_next = !qok_reg ? 6'd0 : (q_count > 7'd63) ? 6'd63 : q_count[5:0];
                bad_next = 1'b0;
                ovf_next = 1'b0;
                st_next = T_IDLE;
            end
            T_ADD:
            begin
                if (!start_d_reg && !started_reg && !sts.busy)
                    st_next = T_OUT;
            end
            T_OUT:
            begin
                ov_next = 1'b1;
                deg_next = '0;
                bad_next = 1'b0;
                ovf_next = sts.ovf;
                st_next = T_IDLE;
            end
            default: st_next = T_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
    assign degree = deg_reg;
    assign bad_cell_type = bad_reg;
    assign list_overflow = ovf_reg;

    `MNDC_ASSERT_IMP(a_no_accept_while_busy, sts.busy, in_stall)
    `MNDC_ASSERT_IMP(a_flags_exclusive, out_valid, !(bad_cell_type && list_overflow))
    `MNDC_ASSERT_NXT(a_query_answers, st_reg == T_QRY, out_valid && !bad_cell_type)
endmodule
